>>> design/wsdo_pkg.sv
// Package for the wall segment draw order block: widths, codes and side classification.
`timescale 1ns / 1ps

package wsdo_pkg;

  // Field and arithmetic widths
  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned CrossW = ProdW + 1;
  localparam int unsigned FracW  = 10;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgCameraX = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCameraY = 1'd1;

  // Result codes
  localparam logic [1:0] OrderNone   = 2'd0;
  localparam logic [1:0] OrderBFirst = 2'd1;
  localparam logic [1:0] OrderAFirst = 2'd2;

  // Sign and zero flags of a truncated side value
  typedef struct packed {
    logic neg;
    logic zero;
  } side_t;

  // Classify trunc(c / 2^FracW): zero when |c| < 2^FracW, negative when c <= -2^FracW
  function automatic side_t side_class(logic signed [CrossW-1:0] c);
    logic  hi_ones;
    logic  hi_zero;
    logic  lo_any;
    side_t s;
    hi_ones = &c[CrossW-1:FracW];
    hi_zero = ~|c[CrossW-1:FracW];
    lo_any  = |c[FracW-1:0];
    s.zero  = hi_zero | (hi_ones & lo_any);
    s.neg   = c[CrossW-1] & ~(hi_ones & lo_any);
    return s;
  endfunction

endpackage

>>> design/wall_segment_draw_order.sv
// Wall segment draw order: decides which of two wall segments is drawn first from the camera.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries the two endpoints of segments A and B.
//   Output channel (out_valid_o / out_stall_i) returns one draw_order_o code per request:
//   0 no ordering (collinear or intersecting), 1 draw B first, 2 draw A first.
//   A request is taken on a rising edge with valid high and stall low.
//   Config channel (cfg_valid_i / cfg_ready_o) writes camera_x (index 0) or camera_y
//   (index 1); ready is always high. Write only while no request is in flight.
// Timing:
//   Three-stage pipeline: input register, product register (twelve 25x25 multipliers),
//   result register. An accepted request passes through all three registers before out_valid_o.
//   Throughput is one request per cycle while out_stall_i is low, set by the product stage.
// Reset:
//   rst_ni clears all pipeline valid bits and sets both camera registers to 0.
// Stall:
//   When out_stall_i holds a result, empty stages still fill; in_stall_o rises only
//   once every stage holds a request.
`timescale 1ns / 1ps

module wall_segment_draw_order (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wsdo_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [wsdo_pkg::CoordW-1:0]           cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [wsdo_pkg::CoordW-1:0]    a_start_x_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    a_start_y_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    a_end_x_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    a_end_y_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    b_start_x_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    b_start_y_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    b_end_x_i,
  input  logic signed [wsdo_pkg::CoordW-1:0]    b_end_y_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            draw_order_o
);

  localparam int unsigned CW = wsdo_pkg::CoordW;
  localparam int unsigned DW = wsdo_pkg::DiffW;
  localparam int unsigned PW = wsdo_pkg::ProdW;
  localparam int unsigned XW = wsdo_pkg::CrossW;

  // camera registers
  logic signed [CW-1:0] cam_x_q, cam_y_q;

  // stage 1: input register
  logic                 v1_q;
  logic signed [CW-1:0] ax0_q, ay0_q, ax1_q, ay1_q, bx0_q, by0_q, bx1_q, by1_q;

  // stage 2: product register
  logic                 v2_q;
  logic signed [PW-1:0] pab0x_d, pab0y_d, pab1x_d, pab1y_d, pacx_d, pacy_d;
  logic signed [PW-1:0] pba0x_d, pba0y_d, pba1x_d, pba1y_d, pbcx_d, pbcy_d;
  logic signed [PW-1:0] pab0x_q, pab0y_q, pab1x_q, pab1y_q, pacx_q, pacy_q;
  logic signed [PW-1:0] pba0x_q, pba0y_q, pba1x_q, pba1y_q, pbcx_q, pbcy_q;

  // stage 3: result register
  logic                 out_valid_q;
  logic [1:0]           draw_order_d, draw_order_q;

  // stage enables: a stage loads when empty or when its contents move on
  logic en1, en2, en3;

  assign en3        = ~out_valid_q | ~out_stall_i;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_stall_o = ~en1;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o  = out_valid_q;
  assign draw_order_o = draw_order_q;

  // camera configuration writes; other indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == wsdo_pkg::CfgCameraX) begin
        cam_x_q <= cfg_data_i;
      end
      if (cfg_index_i == wsdo_pkg::CfgCameraY) begin
        cam_y_q <= cfg_data_i;
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        out_valid_q <= v2_q;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      ax0_q <= a_start_x_i;
      ay0_q <= a_start_y_i;
      ax1_q <= a_end_x_i;
      ay1_q <= a_end_y_i;
      bx0_q <= b_start_x_i;
      by0_q <= b_start_y_i;
      bx1_q <= b_end_x_i;
      by1_q <= b_end_y_i;
    end
  end

  // differences against each segment's first endpoint
  logic signed [DW-1:0] adx, ady, bdx, bdy;
  logic signed [DW-1:0] ab0x, ab0y, ab1x, ab1y, acx, acy;
  logic signed [DW-1:0] ba0x, ba0y, ba1x, ba1y, bcx, bcy;

  always_comb begin
    adx  = {ax1_q[CW-1], ax1_q} - {ax0_q[CW-1], ax0_q};
    ady  = {ay1_q[CW-1], ay1_q} - {ay0_q[CW-1], ay0_q};
    bdx  = {bx1_q[CW-1], bx1_q} - {bx0_q[CW-1], bx0_q};
    bdy  = {by1_q[CW-1], by1_q} - {by0_q[CW-1], by0_q};

    ab0x = {bx0_q[CW-1], bx0_q} - {ax0_q[CW-1], ax0_q};
    ab0y = {by0_q[CW-1], by0_q} - {ay0_q[CW-1], ay0_q};
    ab1x = {bx1_q[CW-1], bx1_q} - {ax0_q[CW-1], ax0_q};
    ab1y = {by1_q[CW-1], by1_q} - {ay0_q[CW-1], ay0_q};
    acx  = {cam_x_q[CW-1], cam_x_q} - {ax0_q[CW-1], ax0_q};
    acy  = {cam_y_q[CW-1], cam_y_q} - {ay0_q[CW-1], ay0_q};

    ba0x = {ax0_q[CW-1], ax0_q} - {bx0_q[CW-1], bx0_q};
    ba0y = {ay0_q[CW-1], ay0_q} - {by0_q[CW-1], by0_q};
    ba1x = {ax1_q[CW-1], ax1_q} - {bx0_q[CW-1], bx0_q};
    ba1y = {ay1_q[CW-1], ay1_q} - {by0_q[CW-1], by0_q};
    bcx  = {cam_x_q[CW-1], cam_x_q} - {bx0_q[CW-1], bx0_q};
    bcy  = {cam_y_q[CW-1], cam_y_q} - {by0_q[CW-1], by0_q};

    // cross product terms, full precision
    pab0x_d = ab0x * ady;
    pab0y_d = ab0y * adx;
    pab1x_d = ab1x * ady;
    pab1y_d = ab1y * adx;
    pacx_d  = acx * ady;
    pacy_d  = acy * adx;
    pba0x_d = ba0x * bdy;
    pba0y_d = ba0y * bdx;
    pba1x_d = ba1x * bdy;
    pba1y_d = ba1y * bdx;
    pbcx_d  = bcx * bdy;
    pbcy_d  = bcy * bdx;
  end

  // stage 2 payload
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pab0x_q <= pab0x_d;
      pab0y_q <= pab0y_d;
      pab1x_q <= pab1x_d;
      pab1y_q <= pab1y_d;
      pacx_q  <= pacx_d;
      pacy_q  <= pacy_d;
      pba0x_q <= pba0x_d;
      pba0y_q <= pba0y_d;
      pba1x_q <= pba1x_d;
      pba1y_q <= pba1y_d;
      pbcx_q  <= pbcx_d;
      pbcy_q  <= pbcy_d;
    end
  end

  // side values and ordering decision
  logic signed [XW-1:0] cab0, cab1, cac, cba0, cba1, cbc;
  wsdo_pkg::side_t      sab0, sab1, sac, sba0, sba1, sbc;
  logic                 na0, na1, nb0, nb1;

  always_comb begin
    cab0 = {pab0x_q[PW-1], pab0x_q} - {pab0y_q[PW-1], pab0y_q};
    cab1 = {pab1x_q[PW-1], pab1x_q} - {pab1y_q[PW-1], pab1y_q};
    cac  = {pacx_q[PW-1], pacx_q} - {pacy_q[PW-1], pacy_q};
    cba0 = {pba0x_q[PW-1], pba0x_q} - {pba0y_q[PW-1], pba0y_q};
    cba1 = {pba1x_q[PW-1], pba1x_q} - {pba1y_q[PW-1], pba1y_q};
    cbc  = {pbcx_q[PW-1], pbcx_q} - {pbcy_q[PW-1], pbcy_q};

    sab0 = wsdo_pkg::side_class(cab0);
    sab1 = wsdo_pkg::side_class(cab1);
    sac  = wsdo_pkg::side_class(cac);
    sba0 = wsdo_pkg::side_class(cba0);
    sba1 = wsdo_pkg::side_class(cba1);
    sbc  = wsdo_pkg::side_class(cbc);

    // a zero side value takes the other endpoint's sign
    na0 = sab0.zero ? sab1.neg : sab0.neg;
    na1 = sab1.zero ? sab0.neg : sab1.neg;
    nb0 = sba0.zero ? sba1.neg : sba0.neg;
    nb1 = sba1.zero ? sba0.neg : sba1.neg;

    priority if (sab0.zero && sab1.zero) begin
      // B lies on A's line
      draw_order_d = wsdo_pkg::OrderNone;
    end else if (na0 == na1) begin
      // B wholly on one side of A: camera's side of A decides
      draw_order_d = (na0 == sac.neg) ? wsdo_pkg::OrderBFirst : wsdo_pkg::OrderAFirst;
    end else if (nb0 == nb1) begin
      // A wholly on one side of B
      draw_order_d = (nb0 == sbc.neg) ? wsdo_pkg::OrderAFirst : wsdo_pkg::OrderBFirst;
    end else begin
      // segments cross
      draw_order_d = wsdo_pkg::OrderNone;
    end
  end

  // stage 3 payload
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      draw_order_q <= draw_order_d;
    end
  end

endmodule
